// ===== rtl/core/lzwc_pkg.sv =====
`timescale 1ns / 1ps
package lzwc_pkg;

	localparam int CODE_BITS   = 12;
	localparam int DICT_CODES  = 4096;
	localparam int FIRST_CODE  = 256;
	localparam int HASH_BITS   = CODE_BITS + 1;
	localparam int BUF_BITS    = CODE_BITS + 8;
	localparam int CNT_BITS    = $clog2(BUF_BITS + 1);
	localparam int QUEUE_DEPTH = 2;
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	// The code space is bounded by both the dictionary size and the code width.
	localparam int CODE_LIMIT  = (DICT_CODES < (1 << CODE_BITS)) ?
		DICT_CODES : (1 << CODE_BITS);

	typedef logic [CODE_BITS-1:0] code_t;
	typedef logic [CODE_BITS:0]   free_t;
	typedef logic [HASH_BITS-1:0] slot_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_stream;
	} in_word_t;

	typedef struct packed {
		logic [7:0] packed_byte;
		logic       last_of_stream;
	} out_word_t;

	// One command from the dictionary side to the bit packer.
	typedef struct packed {
		code_t code_a;
		code_t code_b;
		logic  code_b_valid;
		logic  eos;
	} cmd_t;

	typedef struct packed {
		code_t      prefix;
		logic [7:0] suffix;
		slot_t      slot;
	} dict_entry_t;

endpackage

// ===== rtl/core/lzw_compressor_12bit_top.sv =====
`timescale 1ns / 1ps
// LZW compressor, 12-bit codes packed MSB-first. A stream's first word becomes the match
// and yields a command only if it ends the stream; any other word runs a hash probe (slot
// read, dictionary read, compare, accept), another probe on the next slot per collision,
// and a push step when it emits codes.
// Reset (arst_n low) clears the registers; a pass over all 8192 hash slots then clears them.
module lzw_compressor_12bit_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	output logic                src_stall,
	input  lzwc_pkg::in_word_t  src_word,
	output logic                dst_valid,
	input  logic                dst_stall,
	output lzwc_pkg::out_word_t dst_word
);
	import lzwc_pkg::*;

	// The front end owns the dictionary and turns each input word into at most one
	// command, which names the codes to emit. The back end packs those codes into
	// bytes. The small queue between them lets the dictionary search for the next
	// word run while the packer still drains bytes into a stalled output.
	cmd_t push_cmd;
	cmd_t head;
	logic push;
	logic pop;
	logic q_full;
	logic q_empty;

	lzwc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_word  (src_word),
		.push      (push),
		.push_cmd  (push_cmd),
		.q_full    (q_full)
	);

	lzwc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	// The packer keeps leftover bits between commands, so codes of one stream run
	// together without gaps; the end-of-stream command flushes the partial byte.
	lzwc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_empty   (q_empty),
		.pop       (pop),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_word  (dst_word)
	);

endmodule

// ===== rtl/core/lzwc_queue.sv =====
`timescale 1ns / 1ps
module lzwc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  lzwc_pkg::cmd_t push_cmd,
	input  logic          pop,
	output lzwc_pkg::cmd_t head,
	output logic          full,
	output logic          empty
);
	import lzwc_pkg::*;

	cmd_t                 mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] cnt_q;

	assign full  = (cnt_q == QCNT_BITS'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push && !full, pop && !empty})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("command pushed into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty)) else $error("command popped from an empty queue");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_BITS'(QUEUE_DEPTH)) else $error("queue count out of range");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0 || cnt_q == QCNT_BITS'(QUEUE_DEPTH)) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with count");
`endif

endmodule

// ===== rtl/core/lzwc_front.sv =====
`timescale 1ns / 1ps
module lzwc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_stall,
	input  lzwc_pkg::in_word_t src_word,
	output logic               push,
	output lzwc_pkg::cmd_t     push_cmd,
	input  logic               q_full
);
	import lzwc_pkg::*;

	typedef enum logic [5:0] {
		F_IDLE  = 6'b000001,
		F_SLOT  = 6'b000010,
		F_DICT  = 6'b000100,
		F_CHECK = 6'b001000,
		F_PUSH  = 6'b010000,
		F_CLEAR = 6'b100000
	} fstate_t;

	fstate_t     state_q;
	code_t       match_q;
	logic        mvalid_q;
	free_t       nf_q;
	logic [7:0]  byte_q;
	logic        eos_q;
	slot_t       probe_q;
	slot_t       clr_q;
	cmd_t        cmd_q;

	// Hash slots hold a code; dictionary entries record the slot that owns them,
	// so a slot is live only when its code is assigned and points back at it.
	// After reset every slot is cleared to code zero, which is never live.
	code_t       slot_mem [1 << HASH_BITS];
	dict_entry_t dict_mem [1 << CODE_BITS];
	code_t       slot_rd_q;
	dict_entry_t dict_rd_q;

	logic        accept;
	logic        live;
	logic        pair_hit;
	logic        insert;
	logic        clearing;
	slot_t       hash;
	slot_t       slot_waddr;
	code_t       slot_wdata;

	assign accept    = src_valid && (state_q == F_IDLE);
	assign src_stall = (state_q != F_IDLE);
	assign push      = (state_q == F_PUSH) && !q_full;
	assign push_cmd  = cmd_q;
	assign clearing  = (state_q == F_CLEAR);

	assign hash = {1'b0, match_q} ^ {src_word.data_byte, {(HASH_BITS - 8){1'b0}}};

	assign live = ({1'b0, slot_rd_q} >= free_t'(FIRST_CODE))
		&& ({1'b0, slot_rd_q} < nf_q) && (dict_rd_q.slot == probe_q);
	assign pair_hit = (dict_rd_q.prefix == match_q) && (dict_rd_q.suffix == byte_q);
	assign insert = (state_q == F_CHECK) && !live && (nf_q < free_t'(CODE_LIMIT));

	assign slot_waddr = clearing ? clr_q : probe_q;
	assign slot_wdata = clearing ? '0 : nf_q[CODE_BITS-1:0];

	always_ff @(posedge clk) begin
		slot_rd_q <= slot_mem[probe_q];
		if (clearing || insert) begin
			slot_mem[slot_waddr] <= slot_wdata;
		end
	end

	always_ff @(posedge clk) begin
		dict_rd_q <= dict_mem[slot_rd_q];
		if (insert) begin
			dict_mem[nf_q[CODE_BITS-1:0]] <= '{prefix: match_q, suffix: byte_q, slot: probe_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= F_CLEAR;
			match_q  <= '0;
			mvalid_q <= 1'b0;
			nf_q     <= free_t'(FIRST_CODE);
			byte_q   <= '0;
			eos_q    <= 1'b0;
			probe_q  <= '0;
			clr_q    <= '0;
			cmd_q    <= '0;
		end else begin
			case (state_q)
				F_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= F_IDLE;
					end
				end
				F_IDLE: begin
					if (accept) begin
						byte_q <= src_word.data_byte;
						eos_q  <= src_word.end_of_stream;
						if (!mvalid_q) begin
							match_q <= code_t'(src_word.data_byte);
							if (src_word.end_of_stream) begin
								cmd_q <= '{code_a: code_t'(src_word.data_byte), code_b: '0,
									code_b_valid: 1'b0, eos: 1'b1};
								nf_q    <= free_t'(FIRST_CODE);
								state_q <= F_PUSH;
							end else begin
								mvalid_q <= 1'b1;
							end
						end else begin
							probe_q <= hash;
							state_q <= F_SLOT;
						end
					end
				end
				F_SLOT: begin
					state_q <= F_DICT;
				end
				F_DICT: begin
					state_q <= F_CHECK;
				end
				F_CHECK: begin
					if (live && pair_hit) begin
						match_q <= slot_rd_q;
						if (eos_q) begin
							cmd_q <= '{code_a: slot_rd_q, code_b: '0,
								code_b_valid: 1'b0, eos: 1'b1};
							mvalid_q <= 1'b0;
							nf_q     <= free_t'(FIRST_CODE);
							state_q  <= F_PUSH;
						end else begin
							state_q <= F_IDLE;
						end
					end else if (live) begin
						probe_q <= probe_q + 1'b1;
						state_q <= F_SLOT;
					end else begin
						cmd_q <= '{code_a: match_q, code_b: code_t'(byte_q),
							code_b_valid: eos_q, eos: eos_q};
						match_q <= code_t'(byte_q);
						if (eos_q) begin
							mvalid_q <= 1'b0;
							nf_q     <= free_t'(FIRST_CODE);
						end else if (insert) begin
							nf_q <= nf_q + 1'b1;
						end
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!q_full) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/lzwc_back.sv =====
`timescale 1ns / 1ps
module lzwc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  lzwc_pkg::cmd_t      head,
	input  logic                q_empty,
	output logic                pop,
	output logic                dst_valid,
	input  logic                dst_stall,
	output lzwc_pkg::out_word_t dst_word
);
	import lzwc_pkg::*;

	logic [BUF_BITS-1:0] buf_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [1:0]          lc_q;
	logic                ov_q;
	out_word_t           out_q;

	logic codes_left;
	logic out_free;
	logic load;
	logic emit;
	logic full_byte;
	code_t load_code;

	assign codes_left = (lc_q == 2'd0) || (lc_q == 2'd1 && head.code_b_valid);
	assign out_free   = !ov_q || !dst_stall;
	assign full_byte  = (cnt_q >= CNT_BITS'(8));
	assign load_code  = (lc_q == 2'd0) ? head.code_a : head.code_b;

	always_comb begin
		load = 1'b0;
		emit = 1'b0;
		pop  = 1'b0;
		if (!q_empty) begin
			if (codes_left && !full_byte) begin
				load = 1'b1;
			end else if (full_byte || (!codes_left && head.eos && cnt_q != '0)) begin
				emit = out_free;
			end else begin
				pop = 1'b1;
			end
		end
	end

	assign dst_valid = ov_q;
	assign dst_word  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q <= '0;
			cnt_q <= '0;
			lc_q  <= '0;
			ov_q  <= 1'b0;
			out_q <= '0;
		end else begin
			if (load) begin
				buf_q <= buf_q | ({load_code, 8'h00} >> cnt_q);
				cnt_q <= cnt_q + CNT_BITS'(CODE_BITS);
				lc_q  <= lc_q + 1'b1;
			end
			if (emit) begin
				buf_q <= {buf_q[BUF_BITS-9:0], 8'h00};
				cnt_q <= full_byte ? cnt_q - CNT_BITS'(8) : '0;
				ov_q  <= 1'b1;
				out_q <= '{packed_byte: buf_q[BUF_BITS-1 -: 8],
					last_of_stream: head.eos && !codes_left && (cnt_q <= CNT_BITS'(8))};
			end else if (ov_q && !dst_stall) begin
				ov_q <= 1'b0;
			end
			if (pop) begin
				lc_q <= '0;
			end
		end
	end

endmodule
